// File: hdl/message_record_deframer_unit_macros.svh
// assertion macros for the message record deframer
`ifndef MESSAGE_RECORD_DEFRAMER_UNIT_MACROS_SVH
`define MESSAGE_RECORD_DEFRAMER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on clock, off during reset
`define MRD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deframer assertion failed");

// next-cycle implication
`define MRD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deframer assertion failed");

`else

`define MRD_ASSERT_NOW(label, ante, cons)
`define MRD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: hdl/mrd_pkg.sv
`default_nettype none

package mrd_pkg;

   localparam int LENGTH_BITS_DEFAULT = 32;
   localparam logic [7:0] KEY_LENGTH_RESET = 8'd66;

   // the field a byte belongs to; also the deframer phase
   typedef enum logic [3:0] {
      PH_KEY        = 4'd0,
      PH_HASH_LEN   = 4'd1,
      PH_HASH       = 4'd2,
      PH_DATA_LEN   = 4'd3,
      PH_DATA       = 4'd4,
      PH_TTL        = 4'd5,
      PH_TIMESTAMP  = 4'd6,
      PH_NONCE_LEN  = 4'd7,
      PH_NONCE      = 4'd8
   } phase_type;

   typedef enum logic [1:0] {
      ST_BUSY     = 2'd0,
      ST_OK       = 2'd1,
      ST_TRUNC    = 2'd2,
      ST_OVERSIZE = 2'd3
   } status_type;

endpackage

`default_nettype wire

// File: hdl/message_record_deframer_unit.sv
// a byte accepted into the input register moves on to the result register, from
// which it can be taken (input register, then result register);
// one byte per clock while the result is not held by rsp_stall, as the field
// state between the two registers is updated combinationally for each byte.
// reset (synchronous): both stages empty, phase at key, counters and error
// flag cleared, key length back to 66.
`default_nettype none

module message_record_deframer_unit #(
   parameter int LENGTH_BITS = mrd_pkg::LENGTH_BITS_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write_enable,
   input  wire logic [7:0] csr_write_data,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic [7:0] req_blob_byte,
   input  wire logic       req_blob_last,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic [7:0] rsp_byte_out,
   output      logic [3:0] rsp_field_tag,
   output      logic       rsp_field_end,
   output      logic       rsp_record_end,
   output      logic [1:0] rsp_status
);

`include "message_record_deframer_unit_macros.svh"

   logic [7:0] key_length_ff;

   // input stage
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // field state
   mrd_pkg::phase_type      phase_ff, phase_in;
   logic [LENGTH_BITS-1:0]  bytes_ff, bytes_in;
   logic [LENGTH_BITS-1:0]  accum_ff, accum_in;
   logic                    error_ff, error_in;

   // result stage
   logic                    out_valid_ff, out_valid_in;
   logic [7:0]              out_byte_ff;
   mrd_pkg::phase_type      out_tag_ff, out_tag_in;
   logic                    out_fe_ff, out_fe_in;
   logic                    out_re_ff, out_re_in;
   mrd_pkg::status_type     out_status_ff, out_status_in;

   logic advance;

   // working values
   mrd_pkg::phase_type      ph_eff;
   logic [LENGTH_BITS-1:0]  bt_eff;
   logic [LENGTH_BITS:0]    bt_plus1;
   logic [2:0]              pos;
   logic [63:0]             len_shift;
   logic                    len_fits;
   logic [LENGTH_BITS-1:0]  accum_new;
   logic                    err;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   assign in_valid_in  = (req_valid && !req_stall) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_comb begin
      // a corrupt phase restarts at the key; an empty key goes straight to hash length
      ph_eff = phase_ff;
      bt_eff = bytes_ff;
      if (phase_ff > mrd_pkg::PH_NONCE) begin
         ph_eff = mrd_pkg::PH_KEY;
         bt_eff = '0;
      end
      if (ph_eff == mrd_pkg::PH_KEY && key_length_ff == 8'd0) begin
         ph_eff = mrd_pkg::PH_HASH_LEN;
         bt_eff = '0;
      end

      bt_plus1  = {1'b0, bt_eff} + (LENGTH_BITS+1)'(1);
      pos       = bt_eff[2:0];
      len_shift = 64'(in_byte_ff) << {pos, 3'b000};
      len_fits  = (len_shift >> LENGTH_BITS) == 64'd0;
      accum_new = (pos == 3'd0) ? len_shift[LENGTH_BITS-1:0]
                                : (accum_ff | len_shift[LENGTH_BITS-1:0]);

      phase_in      = ph_eff;
      bytes_in      = bt_eff;
      accum_in      = accum_ff;
      error_in      = error_ff;
      out_tag_in    = ph_eff;
      out_fe_in     = 1'b0;
      out_re_in     = 1'b0;
      out_status_in = mrd_pkg::ST_BUSY;
      err           = 1'b0;

      if (error_ff) begin
         // drop mode: tag frozen until the end of the blob
         out_tag_in    = phase_ff;
         out_status_in = mrd_pkg::ST_OVERSIZE;
         phase_in      = phase_ff;
         bytes_in      = bytes_ff;
      end else begin
         unique case (ph_eff) inside
            mrd_pkg::PH_KEY: begin
               if (bt_plus1 >= {{(LENGTH_BITS-7){1'b0}}, key_length_ff}) begin
                  out_fe_in = 1'b1;
                  phase_in  = mrd_pkg::PH_HASH_LEN;
                  bytes_in  = '0;
               end else begin
                  bytes_in  = bt_plus1[LENGTH_BITS-1:0];
               end
            end
            mrd_pkg::PH_HASH_LEN, mrd_pkg::PH_DATA_LEN, mrd_pkg::PH_NONCE_LEN: begin
               if (!len_fits) begin
                  err = 1'b1;
               end else begin
                  accum_in = accum_new;
                  if (pos == 3'd7) begin
                     out_fe_in = 1'b1;
                     bytes_in  = '0;
                     if (accum_new != '0) begin
                        if (ph_eff == mrd_pkg::PH_HASH_LEN)
                           phase_in = mrd_pkg::PH_HASH;
                        else if (ph_eff == mrd_pkg::PH_DATA_LEN)
                           phase_in = mrd_pkg::PH_DATA;
                        else
                           phase_in = mrd_pkg::PH_NONCE;
                     end else if (ph_eff == mrd_pkg::PH_NONCE_LEN) begin
                        out_re_in = 1'b1;
                        phase_in  = mrd_pkg::PH_KEY;
                     end else if (ph_eff == mrd_pkg::PH_HASH_LEN) begin
                        phase_in  = mrd_pkg::PH_DATA_LEN;
                     end else begin
                        phase_in  = mrd_pkg::PH_TTL;
                     end
                  end else begin
                     bytes_in = LENGTH_BITS'(pos) + LENGTH_BITS'(1);
                  end
               end
            end
            mrd_pkg::PH_HASH, mrd_pkg::PH_DATA, mrd_pkg::PH_NONCE: begin
               if (bt_plus1 >= {1'b0, accum_ff}) begin
                  out_fe_in = 1'b1;
                  bytes_in  = '0;
                  if (ph_eff == mrd_pkg::PH_NONCE) begin
                     out_re_in = 1'b1;
                     phase_in  = mrd_pkg::PH_KEY;
                  end else if (ph_eff == mrd_pkg::PH_HASH) begin
                     phase_in  = mrd_pkg::PH_DATA_LEN;
                  end else begin
                     phase_in  = mrd_pkg::PH_TTL;
                  end
               end else begin
                  bytes_in = bt_plus1[LENGTH_BITS-1:0];
               end
            end
            mrd_pkg::PH_TTL, mrd_pkg::PH_TIMESTAMP: begin
               if (bt_eff >= LENGTH_BITS'(7)) begin
                  out_fe_in = 1'b1;
                  bytes_in  = '0;
                  phase_in  = (ph_eff == mrd_pkg::PH_TTL) ? mrd_pkg::PH_TIMESTAMP
                                                          : mrd_pkg::PH_NONCE_LEN;
               end else begin
                  bytes_in = bt_plus1[LENGTH_BITS-1:0];
               end
            end
            default: begin
               phase_in = mrd_pkg::PH_KEY;
               bytes_in = '0;
            end
         endcase

         if (err) begin
            out_status_in = mrd_pkg::ST_OVERSIZE;
            error_in      = 1'b1;
         end else if (in_last_ff) begin
            out_status_in = (phase_in == mrd_pkg::PH_KEY && bytes_in == '0)
                            ? mrd_pkg::ST_OK : mrd_pkg::ST_TRUNC;
         end
      end

      // end of blob returns to a clean record boundary
      if (in_last_ff) begin
         phase_in = mrd_pkg::PH_KEY;
         bytes_in = '0;
         accum_in = '0;
         error_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff <= mrd_pkg::KEY_LENGTH_RESET;
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         phase_ff      <= mrd_pkg::PH_KEY;
         bytes_ff      <= '0;
         accum_ff      <= '0;
         error_ff      <= 1'b0;
      end else begin
         if (csr_write_enable)
            key_length_ff <= csr_write_data;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            phase_ff <= phase_in;
            bytes_ff <= bytes_in;
            accum_ff <= accum_in;
            error_ff <= error_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_blob_byte;
         in_last_ff <= req_blob_last;
      end
      if (advance) begin
         out_byte_ff   <= in_byte_ff;
         out_tag_ff    <= out_tag_in;
         out_fe_ff     <= out_fe_in;
         out_re_ff     <= out_re_in;
         out_status_ff <= out_status_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_byte_out   = out_byte_ff;
   assign rsp_field_tag  = out_tag_ff;
   assign rsp_field_end  = out_fe_ff;
   assign rsp_record_end = out_re_ff;
   assign rsp_status     = out_status_ff;

   // an oversized length or drop mode never marks a boundary
   `MRD_ASSERT_NOW(a_oversize_no_end,
      out_valid_ff && out_status_ff == mrd_pkg::ST_OVERSIZE, !out_fe_ff && !out_re_ff)
   // a record closes only together with its last field
   `MRD_ASSERT_NOW(a_record_end_field_end, out_valid_ff && out_re_ff,
      out_fe_ff && (out_tag_ff == mrd_pkg::PH_NONCE || out_tag_ff == mrd_pkg::PH_NONCE_LEN))
   // drop mode is entered only from a length prefix
   `MRD_ASSERT_NOW(a_error_in_length, error_ff,
      phase_ff == mrd_pkg::PH_HASH_LEN || phase_ff == mrd_pkg::PH_DATA_LEN
      || phase_ff == mrd_pkg::PH_NONCE_LEN)
   // a held result keeps the field state frozen behind it
   `MRD_ASSERT_NEXT(a_stall_freezes_state, out_valid_ff && rsp_stall && !reset,
      $stable(phase_ff) && $stable(bytes_ff))

endmodule

`default_nettype wire
